@@ design/vslf_pkg.sv @@
// shared types, constants and helper functions for the segment list fetcher
// no dependencies
package vslf_pkg;

    // screen geometry
    localparam int SCREEN_LINES = 300;
    localparam int LINE_PIXELS  = 832;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_HIGH = 1'b1;

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_REQ   = 2'd0;
    localparam logic [1:0] KIND_PIX   = 2'd1;
    localparam logic [1:0] KIND_BLANK = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    // walk phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LINE = 2'd1;
    localparam logic [1:0] PH_DESC = 2'd2;
    localparam logic [1:0] PH_DATA = 2'd3;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [21:0] address;
        logic [63:0] pixels;
        logic [9:0]  pixel_count;
        logic [9:0]  line_index;
        logic        line_end;
    } t_result;

    function automatic logic [21:0] make_addr(input logic [15:0] lo, input logic [15:0] hi);
        make_addr = {hi[3:0], lo, 2'b00};
    endfunction

    // each source bit, lsb first, becomes two pixels
    function automatic logic [63:0] double_bits(input logic [31:0] w);
        logic [63:0] p;
        p = '0;
        for (int i = 0; i < 32; i++) begin
            p[2*i]   = w[i];
            p[2*i+1] = w[i];
        end
        double_bits = p;
    endfunction

    function automatic t_result mk_req(input logic [21:0] addr, input logic [9:0] line);
        t_result r;
        r             = '0;
        r.kind        = KIND_REQ;
        r.address     = addr;
        r.line_index  = line;
        mk_req        = r;
    endfunction

    function automatic t_result mk_out(input logic [1:0] kind, input logic [63:0] pix,
                                       input logic [9:0] cnt, input logic [9:0] line,
                                       input logic last);
        t_result r;
        r             = '0;
        r.kind        = kind;
        r.pixels      = pix;
        r.pixel_count = cnt;
        r.line_index  = line;
        r.line_end    = last;
        mk_out        = r;
    endfunction

endpackage

@@ design/vslf_in_if.sv @@
// request channel into the fetcher: command and memory read data
// no dependencies
interface vslf_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] read_word;

    modport source (output valid, output cmd, output read_word, input ready);
    modport sink   (input valid, input cmd, input read_word, output ready);
endinterface

@@ design/vslf_out_if.sv @@
// result channel out of the fetcher: read requests, pixels, blank runs, frame done
// no dependencies
interface vslf_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [21:0] address;
    logic [63:0] pixels;
    logic [9:0]  pixel_count;
    logic [9:0]  line_index;
    logic        line_end;

    modport source (output valid, output kind, output address, output pixels,
                    output pixel_count, output line_index, output line_end, input ready);
    modport sink   (input valid, input kind, input address, input pixels,
                    input pixel_count, input line_index, input line_end, output ready);
endinterface

@@ design/video_segment_list_fetcher.sv @@
// results: each accepted request writes its results into a 4-entry result queue
// throughput: one request per cycle while the queue holds at most two results; a
//   request yielding two results drains them one by one at the single-result port
// reset: synchronous active-low i_rst_n clears the walk state, the base registers
//   and the result queue; no clearing pass is needed
// uses vslf_pkg, vslf_in_if, vslf_out_if
module video_segment_list_fetcher #(
    parameter int SCREEN_LINES = vslf_pkg::SCREEN_LINES,
    parameter int LINE_PIXELS  = vslf_pkg::LINE_PIXELS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [vslf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [vslf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    vslf_in_if.sink                       i_in,
    vslf_out_if.source                    o_out
);
    import vslf_pkg::*;

    logic [15:0] r_base_low;
    logic [3:0]  r_base_high;

    logic [1:0]  r_phase, n_phase;
    logic [21:0] r_tptr, n_tptr;
    logic [21:0] r_dptr, n_dptr;
    logic [21:0] r_aptr, n_aptr;
    logic [9:0]  r_line, n_line;
    logic [9:0]  r_column, n_column;
    logic [5:0]  r_words, n_words;

    t_result     r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    logic        acc, pop;
    t_result     res0, res1;
    logic [1:0]  push_cnt;

    logic [15:0] w_lo, w_hi;
    logic [21:0] w_addr;
    logic [5:0]  seg_count;
    logic [9:0]  room;
    logic [10:0] blank_full;
    logic [9:0]  blank_len, blank_col;
    logic [6:0]  data_n;
    logic [63:0] data_pix, data_mask;
    logic [9:0]  data_col;
    logic [5:0]  words_dec;
    logic [21:0] aptr_inc;
    logic [9:0]  line_inc;
    logic        frame_last;
    t_result     fin_res;
    logic [1:0]  fin_phase;
    logic [9:0]  fin_line;
    logic [21:0] fin_tptr;

    assign acc        = i_in.valid && i_in.ready;
    assign pop        = o_out.valid && o_out.ready;
    assign i_in.ready = (r_count <= CNT_W'(FIFO_DEPTH - 2));

    assign o_out.valid       = (r_count != '0);
    assign o_out.kind        = r_fifo[r_rd].kind;
    assign o_out.address     = r_fifo[r_rd].address;
    assign o_out.pixels      = r_fifo[r_rd].pixels;
    assign o_out.pixel_count = r_fifo[r_rd].pixel_count;
    assign o_out.line_index  = r_fifo[r_rd].line_index;
    assign o_out.line_end    = r_fifo[r_rd].line_end;

    // word decode and segment arithmetic
    always_comb begin
        w_lo       = i_in.read_word[15:0];
        w_hi       = i_in.read_word[31:16];
        w_addr     = make_addr(w_lo, w_hi);
        // zero count means 32 words
        seg_count  = (w_hi[14:10] == 5'd0) ? 6'd32 : {1'b0, w_hi[14:10]};
        room       = 10'(LINE_PIXELS) - r_column;
        blank_full = {seg_count, 5'b00000};
        blank_len  = (blank_full > {1'b0, room}) ? room : blank_full[9:0];
        blank_col  = r_column + blank_len;
        data_n     = (room < 10'd64) ? room[6:0] : 7'd64;
        data_mask  = data_n[6] ? '1 : ((64'd1 << data_n[5:0]) - 64'd1);
        data_pix   = double_bits(i_in.read_word) & data_mask;
        data_col   = r_column + {3'b000, data_n};
        words_dec  = (r_words != 6'd0) ? r_words - 6'd1 : 6'd0;
        aptr_inc   = r_aptr + 22'd4;
    end

    // end of line: next table entry or frame done
    always_comb begin
        line_inc   = r_line + 10'd1;
        frame_last = (line_inc >= 10'(SCREEN_LINES));
        if (frame_last) begin
            fin_res   = mk_out(KIND_DONE, '0, '0, '0, 1'b0);
            fin_phase = PH_IDLE;
            fin_line  = '0;
            fin_tptr  = r_tptr;
        end else begin
            fin_res   = mk_req(r_tptr, line_inc);
            fin_phase = PH_LINE;
            fin_line  = line_inc;
            fin_tptr  = r_tptr + 22'd4;
        end
    end

    // one step of the walk per accepted request
    always_comb begin
        n_phase  = r_phase;
        n_tptr   = r_tptr;
        n_dptr   = r_dptr;
        n_aptr   = r_aptr;
        n_line   = r_line;
        n_column = r_column;
        n_words  = r_words;
        res0     = '0;
        res1     = '0;
        push_cnt = 2'd0;
        if (i_in.cmd == CMD_START) begin
            n_line   = '0;
            n_column = '0;
            n_words  = '0;
            res0     = mk_req(make_addr(r_base_low, {12'd0, r_base_high}), 10'd0);
            n_tptr   = make_addr(r_base_low, {12'd0, r_base_high}) + 22'd4;
            n_phase  = PH_LINE;
            push_cnt = 2'd1;
        end else begin
            case (r_phase)
                PH_LINE: begin
                    if (i_in.read_word == 32'd0) begin
                        res0     = mk_out(KIND_BLANK, '0, 10'(LINE_PIXELS), r_line, 1'b1);
                        res1     = fin_res;
                        n_phase  = fin_phase;
                        n_line   = fin_line;
                        n_tptr   = fin_tptr;
                        push_cnt = 2'd2;
                    end else begin
                        n_column = '0;
                        res0     = mk_req(w_addr, r_line);
                        n_dptr   = w_addr + 22'd4;
                        n_phase  = PH_DESC;
                        push_cnt = 2'd1;
                    end
                end
                PH_DESC: begin
                    if (w_addr == 22'd0) begin
                        n_column = blank_col;
                        push_cnt = 2'd2;
                        if (blank_col >= 10'(LINE_PIXELS)) begin
                            res0    = mk_out(KIND_BLANK, '0, blank_len, r_line, 1'b1);
                            res1    = fin_res;
                            n_phase = fin_phase;
                            n_line  = fin_line;
                            n_tptr  = fin_tptr;
                        end else begin
                            res0    = mk_out(KIND_BLANK, '0, blank_len, r_line, 1'b0);
                            res1    = mk_req(r_dptr, r_line);
                            n_dptr  = r_dptr + 22'd4;
                        end
                    end else begin
                        n_words  = seg_count;
                        n_aptr   = w_addr;
                        res0     = mk_req(w_addr, r_line);
                        n_phase  = PH_DATA;
                        push_cnt = 2'd1;
                    end
                end
                PH_DATA: begin
                    n_column = data_col;
                    push_cnt = 2'd2;
                    if (data_col >= 10'(LINE_PIXELS)) begin
                        res0    = mk_out(KIND_PIX, data_pix, {3'b000, data_n}, r_line, 1'b1);
                        res1    = fin_res;
                        n_phase = fin_phase;
                        n_line  = fin_line;
                        n_tptr  = fin_tptr;
                    end else begin
                        res0    = mk_out(KIND_PIX, data_pix, {3'b000, data_n}, r_line, 1'b0);
                        n_aptr  = aptr_inc;
                        n_words = words_dec;
                        if (words_dec != 6'd0) begin
                            res1 = mk_req(aptr_inc, r_line);
                        end else begin
                            res1    = mk_req(r_dptr, r_line);
                            n_dptr  = r_dptr + 22'd4;
                            n_phase = PH_DESC;
                        end
                    end
                end
                default: begin
                    // response with nothing outstanding is dropped
                    push_cnt = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_low  <= '0;
            r_base_high <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE_LOW:  r_base_low  <= i_cfg_data;
                CFG_BASE_HIGH: r_base_high <= i_cfg_data[3:0];
                default:       r_base_low  <= r_base_low;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_tptr   <= '0;
            r_dptr   <= '0;
            r_aptr   <= '0;
            r_line   <= '0;
            r_column <= '0;
            r_words  <= '0;
        end else if (acc) begin
            r_phase  <= n_phase;
            r_tptr   <= n_tptr;
            r_dptr   <= n_dptr;
            r_aptr   <= n_aptr;
            r_line   <= n_line;
            r_column <= n_column;
            r_words  <= n_words;
        end
    end

    // result queue payload
    always_ff @(posedge i_clk) begin
        if (acc && push_cnt != 2'd0) begin
            r_fifo[r_wr] <= res0;
        end
        if (acc && push_cnt == 2'd2) begin
            r_fifo[r_wr + PTR_W'(1)] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (acc) begin
                r_wr <= r_wr + PTR_W'(push_cnt);
            end
            if (pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            r_count <= r_count + (acc ? CNT_W'(push_cnt) : CNT_W'(0)) - CNT_W'(pop);
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_start_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_in.cmd == CMD_START |=> r_phase == PH_LINE)
        else $error("start did not begin a table fetch");

    a_idle_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && push_cnt == 2'd0 && !pop |=> $stable(r_count))
        else $error("dropped response changed the queue");

    a_line_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line < 10'(SCREEN_LINES))
        else $error("line counter past the screen");

    a_column_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DESC || r_phase == PH_DATA) |-> r_column < 10'(LINE_PIXELS))
        else $error("segment walk past the line width");
`endif

endmodule
